@@ hdl/aot_pkg.sv @@
// Shared types, character codes and helper functions for the arrow operator tokenizer.
// Depends on nothing; every other file of the block imports it.
package aot_pkg;

    localparam int OFFSET_BITS = 16;   // width of byte position and run length counters
    localparam int FIELD_BITS  = 16;   // width of offset and length fields on the result port

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_MINUS  = 3'd1,
        MODE_LT     = 3'd2,
        MODE_LTDASH = 3'd3,
        MODE_WORD   = 3'd4,
        MODE_NUM    = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        KIND_END     = 3'd0,
        KIND_SEND    = 3'd1,
        KIND_BIJECT  = 3'd2,
        KIND_INHERIT = 3'd3,
        KIND_IS      = 3'd4,
        KIND_WORD    = 3'd5,
        KIND_NUMBER  = 3'd6,
        KIND_ERROR   = 3'd7
    } kind_t;

    // Progress of a word against the keyword "is".
    typedef enum logic [1:0] {
        MATCH_EMPTY = 2'd0,
        MATCH_I     = 2'd1,
        MATCH_IS    = 2'd2,
        MATCH_NONE  = 2'd3
    } match_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LOW_I = 8'h69;
    localparam logic [7:0] CH_LOW_S = 8'h73;

    typedef logic [OFFSET_BITS-1:0] count_t;
    typedef logic [FIELD_BITS-1:0]  field_t;

    typedef struct packed {
        kind_t  kind;
        field_t offset;
        field_t length;
        logic   last;
    } token_t;

    // What the scanner produces for the byte held in the input register.
    typedef struct packed {
        logic   any;      // at least one token
        logic   two;      // two tokens
        token_t first;
        token_t second;
    } scan_res_t;

    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == {OFFSET_BITS{1'b1}}) ? v : count_t'(v + 1'b1);
        return r;
    endfunction

    function automatic field_t to_field(input count_t v);
        return FIELD_BITS'(v);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic match_t next_match(input match_t m, input logic [7:0] b);
        match_t r;
        if (m == MATCH_EMPTY && b == CH_LOW_I) begin
            r = MATCH_I;
        end else if (m == MATCH_I && b == CH_LOW_S) begin
            r = MATCH_IS;
        end else begin
            r = MATCH_NONE;
        end
        return r;
    endfunction

endpackage

@@ hdl/arrow_operator_tokenizer.sv @@
// Top level of the arrow operator tokenizer: input register, scanner, result register.
// Depends on aot_pkg, aot_scan and aot_out_slot.
//
//  channel | direction | handshake         | word carries
//  --------+-----------+-------------------+----------------------------------------------
//  s_      | in        | s_valid / s_ready | s_text_byte
//  m_      | out       | m_valid / m_ready | m_token_kind, m_token_offset, m_token_length,
//          |           |                   | m_last_of_item
//
// Flow: a byte sits in the input register and leaves it when its tokens load into the result
// register, or without waiting if it owes none; a byte that closes a token and also starts an
// error or end token loads two tokens one after the other, as the single result register
// takes one token per cycle while it is free.
// Path: a token reaches m_ through the input register and then the result register; the
// second of two loads after the first.
// Reset: aresetn low at a clock edge clears both valid flags, the scanner to idle and
// offset zero.
// Stalls: a held byte that owes a token waits while the result register is full and
// m_ready is low; s_ready then drops, so s_ready follows m_ready in the same cycle. A held
// byte that owes no token never waits.
module arrow_operator_tokenizer
    import aot_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_token_kind,
    output field_t     m_token_offset,
    output field_t     m_token_length,
    output logic       m_last_of_item
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       phase_reg, phase_next;   // first of two tokens already sent

    scan_res_t res;
    logic      out_free, step_ok, done, load;
    token_t    load_tok;

    aot_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .text_byte (in_byte_reg),
        .commit    (done),
        .res       (res)
    );

    // Advance the held byte when its next token has somewhere to go.
    assign step_ok  = in_valid_reg && (!res.any || out_free);
    assign done     = step_ok && (!res.two || phase_reg);
    assign load     = step_ok && res.any;
    assign load_tok = phase_reg ? res.second : res.first;

    // Take a new word when no byte is held or as soon as the held byte finishes.
    assign s_ready = !in_valid_reg || done;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (done) begin
            in_valid_next = 1'b0;
        end
        phase_next = phase_reg;
        if (step_ok && res.two) begin
            phase_next = !phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
        end
    end

    aot_out_slot u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load),
        .tok            (load_tok),
        .free           (out_free),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_token_kind   (m_token_kind),
        .m_token_offset (m_token_offset),
        .m_token_length (m_token_length),
        .m_last_of_item (m_last_of_item)
    );

    // A second token is only owed while its byte is still held.
    a_phase_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> in_valid_reg)
        else $error("second token pending without a held byte");

    // Never overwrite a token that is still waiting downstream.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free)
        else $error("result register loaded while occupied");

    // The first of two tokens goes out without the last flag.
    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(phase_reg) |-> (m_valid && !m_last_of_item))
        else $error("first of two tokens marked last");

endmodule

@@ hdl/aot_scan.sv @@
// Tokenizer state registers and the per-byte classification logic.
// Depends on aot_pkg.
module aot_scan
    import aot_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] text_byte,
    input  logic       commit,
    output scan_res_t  res
);

    mode_t  mode_reg,  mode_next;
    count_t pos_reg,   pos_next;
    count_t begin_reg, begin_next;
    count_t run_reg,   run_next;
    match_t match_reg, match_next;

    logic   have_p, have_f, consumed, word_ch;
    token_t tok_p, tok_f;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            run_reg   <= '0;
            match_reg <= MATCH_EMPTY;
        end else if (commit) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            run_reg   <= run_next;
            match_reg <= match_next;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        run_next   = run_reg;
        match_next = match_reg;
        have_p     = 1'b0;
        have_f     = 1'b0;
        consumed   = 1'b0;
        word_ch    = is_letter(text_byte) || is_digit(text_byte) || text_byte == CH_UNDER;
        tok_p      = '{kind: KIND_ERROR, offset: to_field(begin_reg),
                       length: field_t'(1), last: 1'b0};
        tok_f      = '{kind: KIND_ERROR, offset: to_field(pos_reg),
                       length: field_t'(1), last: 1'b1};

        // Close or extend the pending token.
        case (mode_reg)
            MODE_MINUS: begin
                have_p = 1'b1;
                if (text_byte == CH_GT) begin
                    tok_p.kind   = KIND_SEND;
                    tok_p.length = field_t'(2);
                    mode_next    = MODE_IDLE;
                    consumed     = 1'b1;
                end
            end
            MODE_LT: begin
                if (text_byte == CH_MINUS) begin
                    mode_next = MODE_LTDASH;
                    run_next  = count_t'(2);
                    consumed  = 1'b1;
                end else begin
                    have_p = 1'b1;
                end
            end
            MODE_LTDASH: begin
                have_p = 1'b1;
                if (text_byte == CH_GT) begin
                    tok_p.kind   = KIND_BIJECT;
                    tok_p.length = field_t'(3);
                    mode_next    = MODE_IDLE;
                    consumed     = 1'b1;
                end else begin
                    tok_p.kind   = KIND_INHERIT;
                    tok_p.length = field_t'(2);
                end
            end
            MODE_WORD: begin
                if (word_ch) begin
                    run_next   = sat_inc(run_reg);
                    match_next = next_match(match_reg, text_byte);
                    consumed   = 1'b1;
                end else begin
                    have_p       = 1'b1;
                    tok_p.kind   = (match_reg == MATCH_IS) ? KIND_IS : KIND_WORD;
                    tok_p.length = to_field(run_reg);
                end
            end
            MODE_NUM: begin
                if (is_digit(text_byte)) begin
                    run_next = sat_inc(run_reg);
                    consumed = 1'b1;
                end else begin
                    have_p       = 1'b1;
                    tok_p.kind   = KIND_NUMBER;
                    tok_p.length = to_field(run_reg);
                end
            end
            default: begin
            end
        endcase

        // Start fresh on any byte the pending token did not take.
        if (consumed) begin
            pos_next = sat_inc(pos_reg);
        end else begin
            mode_next = MODE_IDLE;
            if (text_byte == CH_NUL) begin
                have_f       = 1'b1;
                tok_f.kind   = KIND_END;
                tok_f.length = '0;
                pos_next     = '0;
            end else begin
                pos_next = sat_inc(pos_reg);
                if (text_byte != CH_SPACE && text_byte != CH_TAB) begin
                    begin_next = pos_reg;
                    run_next   = count_t'(1);
                    if (text_byte == CH_MINUS) begin
                        mode_next = MODE_MINUS;
                    end else if (text_byte == CH_LT) begin
                        mode_next = MODE_LT;
                    end else if (is_letter(text_byte) || text_byte == CH_UNDER) begin
                        mode_next  = MODE_WORD;
                        match_next = next_match(MATCH_EMPTY, text_byte);
                    end else if (is_digit(text_byte)) begin
                        mode_next = MODE_NUM;
                    end else begin
                        have_f = 1'b1;
                    end
                end
            end
        end

        tok_p.last = !have_f;
        res.any    = have_p || have_f;
        res.two    = have_p && have_f;
        res.first  = have_p ? tok_p : tok_f;
        res.second = tok_f;
    end

endmodule

@@ hdl/aot_out_slot.sv @@
// Result register of the tokenizer with its valid/ready handshake.
// Depends on aot_pkg.
module aot_out_slot
    import aot_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  token_t     tok,
    output logic       free,
    input  logic       m_ready,
    output logic       m_valid,
    output logic [2:0] m_token_kind,
    output field_t     m_token_offset,
    output field_t     m_token_length,
    output logic       m_last_of_item
);

    logic   valid_reg, valid_next;
    token_t tok_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset; load only when the slot frees up.
    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg <= tok;
        end
    end

    assign m_valid        = valid_reg;
    assign m_token_kind   = 3'(tok_reg.kind);
    assign m_token_offset = tok_reg.offset;
    assign m_token_length = tok_reg.length;
    assign m_last_of_item = tok_reg.last;

endmodule
